// ===== design/rsc_pkg.sv =====
// rsc_pkg: shared types, constants and command codes for the stack calculator
// used by the front, back and top design files of the block
package rsc_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_WORD_WIDTH  = 32;
	localparam int IN_WIDTH        = 32;
	localparam int CMD_WIDTH       = 3;
	localparam int STATUS_WIDTH    = 2;
	localparam int DEPTH_WIDTH     = 7;

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_SQRT = 3'd5,
		CMD_OUT  = 3'd6,
		CMD_HALT = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_REFUSED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_POP1,
		EX_POP2,
		EX_ITER,
		EX_DONE
	} ex_state_t;

endpackage

// ===== design/rsc_front.sv =====
// rsc_front: two-entry input command queue
// depends on rsc_pkg
module rsc_front #(
	parameter int IW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rsc_pkg::cmd_t         in_cmd,
	input  logic signed [IW-1:0]  in_value,
	output logic                  q_valid,
	input  logic                  q_ready,
	output rsc_pkg::cmd_t         q_cmd,
	output logic signed [IW-1:0]  q_value
);
	import rsc_pkg::*;

	cmd_t              cmd_q   [2];
	logic [IW-1:0]     value_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = cmd_q[rp_q];
	assign q_value  = value_q[rp_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q]   <= in_cmd;
			value_q[wp_q] <= in_value;
		end
	end
endmodule

// ===== design/rsc_back.sv =====
// rsc_back: stack memory, sequencer and shared iterative divide / root unit
// depends on rsc_pkg
module rsc_back #(
	parameter int DEPTH = 64,
	parameter int W     = 32,
	parameter int IW    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  rsc_pkg::cmd_t         q_cmd,
	input  logic signed [IW-1:0]  q_value,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  res_valid,
	output logic signed [IW-1:0]  res_value,
	output rsc_pkg::status_t      res_status,
	output logic [rsc_pkg::DEPTH_WIDTH-1:0] res_depth
);
	import rsc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int NW = $clog2(W + 1);
	localparam bit ODD_W = ((W % 2) == 1);

	logic [W-1:0]  mem [DEPTH];
	logic [W-1:0]  rd_q;
	logic [CW-1:0] cnt_q;
	logic          halted_q;
	ex_state_t     st_q, st_d;
	cmd_t          cmd_q;
	logic [W-1:0]  a_q, b_q, acc_q, rem_q, quo_q;
	logic [NW-1:0] it_q;
	status_t       stat_q;
	logic          oval_q;
	logic [W-1:0]  oword_q;
	logic          mem_we;
	logic [W-1:0]  mem_wdata;

	// pop reads of the stack: address below the count
	logic          empty;
	logic [AW-1:0] top_addr;
	assign empty    = (cnt_q == '0);
	assign top_addr = AW'(cnt_q - CW'(1));

	// execution state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= EX_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d    = st_q;
		q_ready = 1'b0;
		case (st_q)
			EX_IDLE: if (q_valid && !rsp_valid) begin
				q_ready = 1'b1;
				st_d    = EX_POP1;
			end
			EX_POP1: st_d = EX_POP2;
			EX_POP2: st_d = EX_ITER;
			EX_ITER: if (it_q == '0) st_d = EX_DONE;
			EX_DONE: st_d = EX_IDLE;
			default: st_d = EX_IDLE;
		endcase
	end

	// divide / root step helpers
	logic [W-1:0] mb, dv_rem, dv_sub;
	logic         na, nb, dv_ge;
	logic [W+1:0] sq_rem, sq_trial;
	assign na     = a_q[W-1];
	assign nb     = b_q[W-1];
	assign mb     = nb ? (W'(0) - b_q) : b_q;
	assign dv_rem = {rem_q[W-2:0], quo_q[W-1]};
	assign dv_ge  = ({rem_q[W-1], dv_rem} >= {1'b0, mb});
	assign dv_sub = dv_rem - mb;
	assign sq_rem = {rem_q, quo_q[W-1:W-2]};
	assign sq_trial = {acc_q, 2'b01};

	logic [W-1:0] pv;
	assign pv = W'($signed(q_value));

	logic [W-1:0] prod;
	assign prod = a_q * b_q;

	// write-back word and enable
	assign mem_we = (st_q == EX_DONE)
	                && (cmd_q inside {CMD_PUSH, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SQRT})
	                && (cnt_q < CW'(DEPTH));

	always_comb begin
		case (cmd_q)
			CMD_PUSH: mem_wdata = a_q;
			CMD_ADD:  mem_wdata = a_q + b_q;
			CMD_SUB:  mem_wdata = a_q - b_q;
			CMD_MUL:  mem_wdata = prod;
			CMD_DIV:  mem_wdata = (b_q == '0) ? b_q
			                      : ((na != nb) ? W'(0) - quo_q : quo_q);
			CMD_SQRT: mem_wdata = nb ? '0 : acc_q;
			default:  mem_wdata = '0;
		endcase
	end

	// stack memory: one write port, registered top read (zero when empty)
	always_ff @(posedge clk) begin
		if (mem_we) mem[cnt_q[AW-1:0]] <= mem_wdata;
		rd_q <= empty ? '0 : mem[top_addr];
	end

	// datapath and stack count updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			halted_q <= 1'b0;
			oval_q   <= 1'b0;
			cmd_q    <= CMD_PUSH;
			stat_q   <= ST_OK;
			oword_q  <= '0;
		end else begin
			case (st_q)
				EX_IDLE: if (q_ready) begin
					a_q <= pv;
					if (halted_q) begin
						stat_q <= ST_REFUSED;
						cmd_q  <= CMD_HALT;
					end else begin
						cmd_q <= q_cmd;
						if (q_cmd inside {CMD_PUSH, CMD_HALT}) begin
							stat_q <= ST_OK;
							if (q_cmd == CMD_HALT) halted_q <= 1'b1;
						end else if (empty) begin
							stat_q <= ST_UNDERFLOW;
						end else begin
							stat_q <= ST_OK;
							cnt_q  <= cnt_q - CW'(1);
						end
					end
				end else if (rsp_valid && rsp_ready) begin
					oval_q <= 1'b0;
				end
				EX_POP1: begin
					// first popped word is the top
					b_q <= rd_q;
					if (cmd_q inside {CMD_ADD, CMD_SUB, CMD_MUL}
					    || (cmd_q == CMD_DIV && rd_q != '0)) begin
						if (!empty) cnt_q <= cnt_q - CW'(1);
						else if (stat_q == ST_OK) stat_q <= ST_UNDERFLOW;
					end
				end
				EX_POP2: begin
					if (cmd_q inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV}) a_q <= rd_q;
					else if (cmd_q == CMD_SQRT) a_q <= b_q;
					rem_q <= '0;
					acc_q <= '0;
					it_q  <= NW'(W);
					// odd word width: shift so root bit pairs line up with bit 0
					quo_q <= (cmd_q == CMD_DIV) ? (rd_q[W-1] ? W'(0) - rd_q : rd_q)
					         : (ODD_W ? (b_q << 1) : b_q);
				end
				EX_ITER: begin
					if (it_q != '0) begin
						it_q <= it_q - NW'(1);
						if (cmd_q == CMD_DIV) begin
							quo_q <= {quo_q[W-2:0], dv_ge};
							rem_q <= dv_ge ? dv_sub : dv_rem;
						end else if (cmd_q == CMD_SQRT && it_q[0] == 1'b0) begin
							// one result bit per two input bits
							quo_q <= {quo_q[W-3:0], 2'b00};
							if (sq_rem >= sq_trial) begin
								rem_q <= W'(sq_rem - sq_trial);
								acc_q <= {acc_q[W-2:0], 1'b1};
							end else begin
								rem_q <= W'(sq_rem);
								acc_q <= {acc_q[W-2:0], 1'b0};
							end
						end
					end
				end
				EX_DONE: begin
					oval_q  <= 1'b1;
					oword_q <= (cmd_q == CMD_OUT) ? b_q : '0;
					if (cmd_q inside {CMD_PUSH, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV,
					                  CMD_SQRT}) begin
						if (cnt_q >= CW'(DEPTH)) begin
							if (stat_q == ST_OK) stat_q <= ST_OVERFLOW;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid  = oval_q && (st_q == EX_IDLE);
	assign res_valid  = (cmd_q == CMD_OUT) && (stat_q != ST_REFUSED);
	assign res_value  = IW'($signed(oword_q));
	assign res_status = stat_q;
	assign res_depth  = DEPTH_WIDTH'(cnt_q);
endmodule

// ===== design/rpn_stack_calculator_top.sv =====
// stack calculator: two-command front queue, back end runs one command at a time
// every command walks pop, pop, a divide / root loop and a write-back
// the back end takes the next command only once the result of the last one is taken
// reset clears stack count, halt flag and handshake state at once; stack memory is not cleared
module rpn_stack_calculator_top #(
	parameter int STACK_DEPTH = rsc_pkg::DEF_STACK_DEPTH,
	parameter int WORD_WIDTH  = rsc_pkg::DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            cmd,
	input  logic signed [31:0]    push_value,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  out_valid,
	output logic signed [31:0]    out_value,
	output logic [1:0]            status,
	output logic [6:0]            depth_after
);
	import rsc_pkg::*;

	logic  q_valid, q_ready;
	cmd_t  q_cmd;
	logic signed [IN_WIDTH-1:0] q_value;
	status_t st;

	rsc_front #(.IW(IN_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.in_cmd(cmd_t'(cmd)), .in_value(push_value),
		.q_valid, .q_ready, .q_cmd, .q_value
	);

	rsc_back #(.DEPTH(STACK_DEPTH), .W(WORD_WIDTH), .IW(IN_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd, .q_value,
		.rsp_valid(res_valid), .rsp_ready(res_ready),
		.res_valid(out_valid), .res_value(out_value),
		.res_status(st), .res_depth(depth_after)
	);

	assign status = st;
endmodule

// ===== design/rsc_checker.sv =====
// rsc_checker: port-level checks of the stack calculator
// depends on rpn_stack_calculator_top ports
module rsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        out_valid,
	input logic [1:0]  status,
	input logic [6:0]  depth_after,
	input logic [31:0] out_value
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_value) && $stable(status))
		else $error("result changed while stalled");
	// depth never above 64
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> depth_after <= 7'd64)
		else $error("depth out of range");
	// refused command emits nothing
	a_ref: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == 2'd3 |-> !out_valid)
		else $error("refused command emitted");
endmodule

bind rpn_stack_calculator_top rsc_checker u_chk (.*);
